// ----- sv/lssr_pkg.sv -----
// Shared types, constants and helper functions for the level sensor speed ramp.
`default_nettype none

package lssr_pkg;

  // Fixed-point format of speeds and targets.
  localparam int FRACTION_BITS = 14;
  localparam int SPEED_W       = 16;
  localparam int DIFF_W        = SPEED_W + 1;
  localparam int ONE_Q         = 1 << FRACTION_BITS;
  localparam int HALF_Q        = ONE_Q / 2;

  // A magnitude counts as near zero when mag * 10000 < 1.0.
  localparam int NEAR_ZERO_MAX = (ONE_Q - 1) / 10000;

  // Input and register widths.
  localparam int BYTE_W    = 8;
  localparam int LEVEL_W   = 5;
  localparam int COUNT_W   = 16;
  localparam int STEP_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int EVENT_W   = 3;
  localparam int OUT_W     = 24;

  localparam logic [2:0] HEADER_CODE = 3'b010;
  localparam logic [COUNT_W-1:0] REPEAT_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0] TIMEOUT_RST     = COUNT_W'(20);
  localparam logic [STEP_W-1:0]  STEP_UP_RST     = STEP_W'(819);
  localparam logic [STEP_W-1:0]  STEP_RETURN_RST = STEP_W'(164);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_TIMEOUT = 2'd0,
    REG_STEP_UP        = 2'd1,
    REG_STEP_RETURN    = 2'd2
  } cfg_reg_t;

  // Event codes reported with each result word.
  typedef enum logic [EVENT_W-1:0] {
    EV_REPEAT     = 3'd0,
    EV_NEW_LEVEL  = 3'd1,
    EV_NOT_ONEHOT = 3'd2,
    EV_STALE      = 3'd3,
    EV_BAD_HEADER = 3'd4
  } event_t;

  // Inputs of the ramp stage.
  typedef struct packed {
    logic signed [SPEED_W-1:0] target;
    logic signed [SPEED_W-1:0] speed;
    logic [STEP_W-1:0]         step_up;
    logic [STEP_W-1:0]         step_return;
  } ramp_in_t;

  // Target speed for a one-hot level field: index/2 - 1 in fixed point.
  function automatic logic signed [SPEED_W-1:0] level_target(input logic [LEVEL_W-1:0] lvl);
    logic signed [SPEED_W-1:0] t;
    begin
      case (lvl)
        5'b00001: t = SPEED_W'(-ONE_Q);
        5'b00010: t = SPEED_W'(-HALF_Q);
        5'b00100: t = '0;
        5'b01000: t = SPEED_W'(HALF_Q);
        5'b10000: t = SPEED_W'(ONE_Q);
        default:  t = '0;
      endcase
      return t;
    end
  endfunction

  // True when exactly one level bit is set.
  function automatic logic level_onehot(input logic [LEVEL_W-1:0] lvl);
    return (lvl != '0) && ((lvl & (lvl - LEVEL_W'(1))) == '0);
  endfunction

endpackage

`default_nettype wire

// ----- sv/lssr_ramp.sv -----
// Ramp stage: moves the speed one step toward the target, snapping when close.
`default_nettype none

module lssr_ramp
  import lssr_pkg::*;
(
  input  var ramp_in_t                  ramp_in,
  output logic signed [SPEED_W-1:0]     speed_next
);

  logic signed [DIFF_W-1:0] diff_up;
  logic signed [DIFF_W-1:0] diff_down;
  logic signed [DIFF_W-1:0] step;
  logic signed [DIFF_W-1:0] speed_ext;
  logic signed [DIFF_W-1:0] sum;
  logic                     moving_up;
  logic                     positive;

  // Distances in both directions, one bit wider than the speed.
  assign speed_ext = DIFF_W'(ramp_in.speed);
  assign diff_up   = DIFF_W'(ramp_in.target) - speed_ext;
  assign diff_down = speed_ext - DIFF_W'(ramp_in.target);
  assign moving_up = ramp_in.target > ramp_in.speed;
  assign positive  = ramp_in.speed > 0;

  // Up step when moving away from zero, return step when moving toward it or up from zero.
  always_comb begin
    if (moving_up == positive) begin
      step = DIFF_W'({1'b0, ramp_in.step_up});
    end else begin
      step = DIFF_W'({1'b0, ramp_in.step_return});
    end
  end

  assign sum = moving_up ? (speed_ext + step) : (speed_ext - step);

  // Snap to the target once the remaining distance is below the step.
  always_comb begin
    if (ramp_in.target == ramp_in.speed) begin
      speed_next = ramp_in.speed;
    end else if (moving_up && (diff_up < step)) begin
      speed_next = ramp_in.target;
    end else if (!moving_up && (diff_down < step)) begin
      speed_next = ramp_in.target;
    end else begin
      speed_next = SPEED_W'(sum);
    end
  end

endmodule

`default_nettype wire

// ----- sv/level_sensor_speed_ramp.sv -----
// Top level of the level sensor speed ramp.
`default_nettype none

// Takes one sensor byte per word on the slave stream and returns one result
// word per byte on the master stream. A byte is accepted in every cycle in
// which the result register is empty or being drained, so the block sustains
// one byte per clock; its result appears in the result register in the cycle
// after acceptance. The rate rests on the state update loop (header check,
// level decode, repeat counter and one ramp add and compare), which is
// combinational. Configuration writes take effect at the next clock edge
// and are meant for idle periods. Speeds are signed Q1.14.

module level_sensor_speed_ramp
  import lssr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Sensor byte stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] sample_byte
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // [15:0] speed, [16] release_res,
                                          // [19:17] event_res, [23:20] zero
);

  // Configuration registers.
  logic [COUNT_W-1:0] sample_timeout;
  logic [STEP_W-1:0]  step_up;
  logic [STEP_W-1:0]  step_return;

  // Block state.
  logic [BYTE_W-1:0]         last_byte, last_byte_next;
  logic [COUNT_W-1:0]        repeat_count, repeat_count_next;
  logic signed [SPEED_W-1:0] target_speed, target_speed_next;
  logic signed [SPEED_W-1:0] speed_now, speed_next;
  logic                      release_flag, release_flag_next;
  event_t                    event_next;

  // Result register.
  logic signed [SPEED_W-1:0] out_speed;
  logic                      out_release;
  event_t                    out_event;

  logic                      accept;
  logic                      header_ok;
  logic [LEVEL_W-1:0]        level;
  logic signed [SPEED_W-1:0] ramped;
  logic [SPEED_W-1:0]        magnitude;
  ramp_in_t                  ramp_in;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign header_ok = s_tdata[7:5] == HEADER_CODE;
  assign level     = s_tdata[LEVEL_W-1:0];
  assign magnitude = speed_now < 0 ? SPEED_W'(-speed_now) : SPEED_W'(speed_now);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timeout <= TIMEOUT_RST;
      step_up        <= STEP_UP_RST;
      step_return    <= STEP_RETURN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_TIMEOUT: sample_timeout <= cfg_data;
        REG_STEP_UP:        step_up        <= cfg_data[STEP_W-1:0];
        REG_STEP_RETURN:    step_return    <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte classification, target and release update.
  always_comb begin
    last_byte_next    = last_byte;
    repeat_count_next = repeat_count;
    target_speed_next = target_speed;
    release_flag_next = release_flag;
    event_next        = EV_REPEAT;
    if (!header_ok) begin
      release_flag_next = 1'b1;
      target_speed_next = '0;
      event_next        = EV_BAD_HEADER;
    end else if (s_tdata != last_byte) begin
      last_byte_next    = s_tdata;
      repeat_count_next = '0;
      if (repeat_count < sample_timeout) begin
        if (level_onehot(level)) begin
          target_speed_next = level_target(level);
          release_flag_next = 1'b0;
          event_next        = EV_NEW_LEVEL;
        end else begin
          event_next = EV_NOT_ONEHOT;
        end
      end else begin
        target_speed_next = '0;
        if (magnitude <= SPEED_W'(NEAR_ZERO_MAX)) begin
          release_flag_next = 1'b1;
        end
        event_next = EV_STALE;
      end
    end else if (repeat_count != REPEAT_MAX) begin
      repeat_count_next = repeat_count + COUNT_W'(1);
    end
  end

  // Ramp toward the updated target; a bad header leaves the speed alone.
  assign ramp_in = '{target: target_speed_next, speed: speed_now,
                     step_up: step_up, step_return: step_return};

  lssr_ramp u_ramp (
    .ramp_in    (ramp_in),
    .speed_next (ramped)
  );

  assign speed_next = header_ok ? ramped : speed_now;

  // State update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte    <= '0;
      repeat_count <= '0;
      target_speed <= '0;
      speed_now    <= '0;
      release_flag <= 1'b1;
    end else if (accept) begin
      last_byte    <= last_byte_next;
      repeat_count <= repeat_count_next;
      target_speed <= target_speed_next;
      speed_now    <= speed_next;
      release_flag <= release_flag_next;
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_speed   <= speed_next;
      out_release <= release_flag_next;
      out_event   <= event_next;
    end
  end

  assign m_tdata = {4'b0000, out_event, out_release, out_speed};

endmodule

`default_nettype wire

// ----- sv/lssr_checker.sv -----
// Port-level checks for the level sensor speed ramp, bound to the top level.
`default_nettype none

module lssr_checker
  import lssr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_W-1:0]   m_tdata
);

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Every accepted byte shows a result word in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted byte gave no result word");

  // A bad header always releases; a new level never does.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[19:17] == EV_BAD_HEADER) |-> m_tdata[16])
    else $error("bad header without release");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[19:17] == EV_NEW_LEVEL) |-> !m_tdata[16])
    else $error("new level still released");

  // Speed never leaves the range of -1.0 to 1.0.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) >= -ONE_Q) && ($signed(m_tdata[15:0]) <= ONE_Q))
    else $error("speed out of range");

endmodule

bind level_sensor_speed_ramp lssr_checker u_lssr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the level sensor speed ramp, with directed and random bytes.
module testbench;
  import lssr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Length of a long repeat run that stays well under the largest timeout.
  localparam int LONG_RUN = 40;

  // One expected result word.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      release_on;
    event_t                    ev;
  } ramp_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SAMPLE_TIMEOUT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  // Predicted block state and register copies.
  logic [COUNT_W-1:0] trust_window;
  logic [STEP_W-1:0]  ramp_up_step;
  logic [STEP_W-1:0]  ramp_down_step;
  logic [BYTE_W-1:0]  held_byte;
  logic [COUNT_W-1:0] repeat_run;
  int                 target_q14;
  int                 speed_q14;
  logic               release_q;

  ramp_result_t      pending_results[$];
  ramp_result_t      head_result;
  logic [BYTE_W-1:0] last_sent = '0;
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  int                error_count = 0;
  int                cycle_count = 0;

  always #6 clk = ~clk;

  level_sensor_speed_ramp u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Sensor byte with a valid header and a single level bit.
  function automatic logic [BYTE_W-1:0] level_byte(input int idx);
    return {HEADER_CODE, 5'(1 << idx)};
  endfunction

  // Advances the predicted state by one byte and returns the result it produces.
  function automatic ramp_result_t advance_speed_ramp(input logic [BYTE_W-1:0] b);
    ramp_result_t r;
    int           lvl_idx;
    int           mag;
    int           stp;
    event_t       ev;
    if (b[7:5] != HEADER_CODE) begin
      release_q  = 1'b1;
      target_q14 = 0;
      ev         = EV_BAD_HEADER;
    end else begin
      if (b != held_byte) begin
        if (repeat_run < trust_window) begin
          // Decode the level field; -2 marks several bits set.
          lvl_idx = -1;
          for (int i = 0; i < LEVEL_W; i++) begin
            if (b[i]) begin
              lvl_idx = (lvl_idx == -1) ? i : -2;
            end
          end
          if (lvl_idx >= 0) begin
            target_q14 = lvl_idx * (ONE_Q / 2) - ONE_Q;
            release_q  = 1'b0;
            ev         = EV_NEW_LEVEL;
          end else begin
            ev = EV_NOT_ONEHOT;
          end
        end else begin
          // Stale change: the near-zero test uses the speed before the ramp.
          mag        = (speed_q14 < 0) ? -speed_q14 : speed_q14;
          target_q14 = 0;
          if (mag * 10000 < ONE_Q) begin
            release_q = 1'b1;
          end
          ev = EV_STALE;
        end
        held_byte  = b;
        repeat_run = '0;
      end else begin
        if (repeat_run != REPEAT_MAX) begin
          repeat_run = repeat_run + 1'b1;
        end
        ev = EV_REPEAT;
      end
      // Ramp: larger magnitude uses the up step, smaller the down step, as does a rise from zero.
      if (target_q14 > speed_q14) begin
        stp = (speed_q14 > 0) ? int'(ramp_up_step) : int'(ramp_down_step);
        if (target_q14 - speed_q14 < stp) speed_q14 = target_q14;
        else speed_q14 = speed_q14 + stp;
      end else if (target_q14 < speed_q14) begin
        stp = (speed_q14 > 0) ? int'(ramp_down_step) : int'(ramp_up_step);
        if (speed_q14 - target_q14 < stp) speed_q14 = target_q14;
        else speed_q14 = speed_q14 - stp;
      end
    end
    r.speed      = speed_q14[SPEED_W-1:0];
    r.release_on = release_q;
    r.ev         = ev;
    return r;
  endfunction

  // Sends one byte, with random idle cycles ahead of it, and records its result.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(advance_speed_ramp(b));
    last_sent = b;
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE_TIMEOUT: trust_window = value;
      REG_STEP_UP:        ramp_up_step = value[STEP_W-1:0];
      REG_STEP_RETURN:    ramp_down_step = value[STEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ramp_config(input int timeout, input int up, input int down);
    wait_drained();
    write_reg(REG_SAMPLE_TIMEOUT, CFG_W'(timeout));
    write_reg(REG_STEP_UP, CFG_W'(up));
    write_reg(REG_STEP_RETURN, CFG_W'(down));
  endtask

  // Every level from reset, repeats, not-one-hot fields and bad headers.
  task automatic test_levels();
    send_byte({HEADER_CODE, 5'b00000});
    send_byte(level_byte(4));
    send_byte(level_byte(4));
    send_byte(level_byte(4));
    send_byte(level_byte(0));
    send_byte(level_byte(0));
    send_byte(level_byte(1));
    send_byte(level_byte(2));
    send_byte(level_byte(3));
    send_byte(level_byte(3));
    send_byte({HEADER_CODE, 5'b11111});
    send_byte({HEADER_CODE, 5'b00011});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hBF);
    send_byte(level_byte(4));
  endtask

  // Stale changes, twice, both with the speed away from zero.
  task automatic test_stale();
    set_ramp_config(2, 819, 164);
    send_byte(level_byte(2));
    repeat (3) send_byte(level_byte(2));
    send_byte(level_byte(3));
    // Hold off here until the block has returned everything.
    wait_drained();
    send_byte(level_byte(4));
    repeat (3) send_byte(level_byte(4));
    send_byte(level_byte(0));
  endtask

  // With both steps at zero the speed must not move.
  task automatic test_step_zero();
    set_ramp_config(20, 0, 0);
    send_byte(level_byte(4));
    send_byte(level_byte(4));
    send_byte(level_byte(0));
    send_byte(level_byte(0));
  endtask

  // Timeout at both ends, with a long repeat run under the largest timeout.
  task automatic test_timeout_limits();
    set_ramp_config(0, 16384, 16384);
    send_byte(level_byte(4));
    send_byte(level_byte(0));
    send_byte(level_byte(3));
    set_ramp_config(65535, 16384, 16384);
    send_byte(level_byte(4));
    repeat (LONG_RUN) send_byte(level_byte(4));
    send_byte(level_byte(0));
    send_byte(level_byte(1));
  endtask

  // Random bytes: mostly level changes and repeat runs, some malformed ones.
  task automatic run_random(input int count);
    int                sent;
    int                kind;
    int                run;
    int                long_cap;
    logic [BYTE_W-1:0] b;
    logic [LEVEL_W-1:0] lvl;
    logic [2:0]        hdr;
    sent = 0;
    long_cap = (trust_window < 40) ? int'(trust_window) + 3 : 40;
    while (sent < count) begin
      kind = $urandom_range(99);
      run  = 1;
      if (kind < 50) begin
        b = level_byte($urandom_range(4));
      end else if (kind < 70) begin
        b = last_sent;
        run = ($urandom_range(3) == 0) ? $urandom_range(long_cap, 1) : $urandom_range(4, 1);
      end else if (kind < 82) begin
        do lvl = LEVEL_W'($urandom_range(31));
        while (lvl != '0 && (lvl & (lvl - 1'b1)) == '0);
        b = {HEADER_CODE, lvl};
      end else if (kind < 94) begin
        do hdr = 3'($urandom_range(7)); while (hdr == HEADER_CODE);
        b = {hdr, 5'($urandom_range(31))};
      end else begin
        b = BYTE_W'($urandom_range(255));
      end
      repeat (run) send_byte(b);
      sent = sent + run;
    end
  endtask

  // Random traffic under several register settings and idle patterns.
  task automatic test_random_phases();
    set_ramp_config(20, 819, 164);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(170);

    set_ramp_config(4, 16384, 1);
    sender_idle_pct = 51;
    receiver_stall_pct = 0;
    run_random(170);

    set_ramp_config(65535, 1, 16384);
    sender_idle_pct = 0;
    receiver_stall_pct = 51;
    run_random(170);

    set_ramp_config(8, $urandom_range(16384, 1), $urandom_range(16384, 1));
    sender_idle_pct = 9;
    receiver_stall_pct = 9;
    run_random(170);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_tdata);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_tdata[15:0] != head_result.speed) begin
          $display("%0t: speed expected %0d, got %0d", $time,
                   head_result.speed, $signed(m_tdata[15:0]));
          error_count++;
        end
        if (m_tdata[16] != head_result.release_on) begin
          $display("%0t: release expected %0d, got %0d", $time,
                   head_result.release_on, m_tdata[16]);
          error_count++;
        end
        if (m_tdata[19:17] != head_result.ev) begin
          $display("%0t: event expected %0d, got %0d", $time,
                   head_result.ev, m_tdata[19:17]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    trust_window   = TIMEOUT_RST;
    ramp_up_step   = STEP_UP_RST;
    ramp_down_step = STEP_RETURN_RST;
    held_byte      = '0;
    repeat_run     = '0;
    target_q14     = 0;
    speed_q14      = 0;
    release_q      = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_levels();
    test_stale();
    test_step_zero();
    test_timeout_limits();
    test_random_phases();
    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
